[rtl/core/rpc_pkg.sv]
// Package for the range predecessor code block: field widths, request codes,
// the no-result code and the controller state type. No dependencies.
package rpc_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 11;
    localparam int IDX_W  = 10;
    localparam int OFF_W  = 10;
    localparam int CODE_W = 13;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [CODE_W-1:0] CODE_NONE = 13'h1FFE;

    typedef enum logic [1:0] {
        S_IDLE,
        S_AIM,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

[rtl/core/rpc_seq_mem.sv]
// Sequence store: one write port and one read port, read data registered.
// Depends on rpc_pkg for the element width.
module rpc_seq_mem
    import rpc_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/range_predecessor_code.sv]
// Top level of the range predecessor code block: request channel, result
// channel, length register and scan controller. Uses rpc_pkg and rpc_seq_mem.
//
//  Channel   Direction  Handshake               Payload
//  in        request    i_in_valid/o_in_stall   i_req_type, i_elem_index,
//                                               i_elem_value, i_range_start,
//                                               i_range_end
//  out       result     o_out_valid/i_out_stall o_found, o_pred_offset,
//                                               o_equal_flag, o_code, o_terminal
//  cfg       write      i_cfg_valid/o_cfg_ready i_cfg_data (sequence length)
//
// A write request is taken in the idle state and leaves the controller idle. A
// query that scans passes the aim, scan and result states: one read of the aim
// element, one stored element per cycle through the single read port of the
// store, and the posting of the result. A query with nothing to scan goes
// straight to the result state. The result register frees the block once
// the result is posted; a stalled result holds the block in its last state.
// Reset clears the controller, the result valid and the length, not the store.
module range_predecessor_code
    import rpc_pkg::*;
#(
    parameter int MAX_LEN = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_req_type,
    input  logic [IDX_W-1:0]         i_elem_index,
    input  logic signed [DATA_W-1:0] i_elem_value,
    input  logic signed [POS_W-1:0]  i_range_start,
    input  logic [POS_W-1:0]         i_range_end,

    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_found,
    output logic [OFF_W-1:0]         o_pred_offset,
    output logic                     o_equal_flag,
    output logic signed [CODE_W-1:0] o_code,
    output logic                     o_terminal,

    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [POS_W-1:0]         i_cfg_data
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    t_state r_state, n_state;

    logic [POS_W-1:0]         r_seq_length;
    logic signed [POS_W-1:0]  r_a;
    logic [POS_W-1:0]         r_b;
    logic [POS_W-1:0]         r_start_pos;
    logic [POS_W-1:0]         r_cmp_pos;
    logic                     r_term;
    logic                     r_found;
    logic [POS_W-1:0]         r_best_pos;
    logic signed [DATA_W-1:0] r_best_val;
    logic signed [DATA_W-1:0] r_aim;

    logic                     r_out_valid;
    logic                     r_out_found;
    logic [OFF_W-1:0]         r_out_offset;
    logic                     r_out_equal;
    logic [CODE_W-1:0]        r_out_code;
    logic                     r_out_term;

    logic                     in_acc;
    logic                     is_query;
    logic                     q_term;
    logic                     q_scan;
    logic [POS_W-1:0]         q_start;
    logic                     wr_en;
    logic [AW-1:0]            rd_addr;
    logic [DATA_W-1:0]        rd_data;
    logic signed [DATA_W-1:0] rd_val;
    logic [POS_W-1:0]         cmp_next;
    logic                     scan_last;
    logic                     take;
    logic                     out_free;
    logic [CODE_W-1:0]        res_d;
    logic                     res_eq;
    logic [CODE_W-1:0]        res_code;
    logic [OFF_W-1:0]         res_off;

    assign o_cfg_ready = 1'b1;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign is_query = (i_req_type == REQ_QUERY);
    assign q_term   = (i_range_end == r_seq_length);
    // A negative start scans from position 0; the offset is still taken from a.
    assign q_start  = i_range_start[POS_W-1] ? '0 : POS_W'(i_range_start);
    assign q_scan   = !q_term && (i_range_end < r_seq_length)
                      && (32'(i_range_end) < 32'(MAX_LEN)) && (q_start < i_range_end);

    assign rd_val    = $signed(rd_data);
    assign cmp_next  = POS_W'(r_cmp_pos + 1'b1);
    assign scan_last = (cmp_next == r_b);
    // Ties go to the later position, hence the greater-or-equal test.
    assign take      = (rd_val <= r_aim) && (!r_found || (rd_val >= r_best_val));
    assign out_free  = !r_out_valid || !i_out_stall;

    rpc_seq_mem #(
        .DEPTH (MAX_LEN),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(i_elem_index)),
        .i_wr_data (i_elem_value),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && is_query) begin
                    n_state = q_scan ? S_AIM : S_DONE;
                end
            end
            S_AIM:  n_state = S_SCAN;
            S_SCAN: begin
                if (scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        wr_en      = 1'b0;
        rd_addr    = AW'(r_cmp_pos);
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                wr_en      = in_acc && !is_query && (32'(i_elem_index) < 32'(MAX_LEN));
                rd_addr    = AW'(i_range_end);
            end
            S_AIM:   rd_addr = AW'(r_start_pos);
            S_SCAN:  rd_addr = AW'(cmp_next);
            S_DONE:  rd_addr = AW'(r_cmp_pos);
            default: rd_addr = AW'(r_cmp_pos);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_seq_length <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_seq_length <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc && is_query) begin
            r_a         <= i_range_start;
            r_b         <= i_range_end;
            r_start_pos <= q_start;
            r_term      <= q_term;
            r_found     <= 1'b0;
        end
        if (r_state == S_AIM) begin
            r_aim     <= rd_val;
            r_cmp_pos <= r_start_pos;
        end
        if (r_state == S_SCAN) begin
            if (take) begin
                r_found    <= 1'b1;
                r_best_pos <= r_cmp_pos;
                r_best_val <= rd_val;
            end
            r_cmp_pos <= cmp_next;
        end
    end

    assign res_d   = {2'b00, r_best_pos} - {{2{r_a[POS_W-1]}}, r_a};
    assign res_eq  = r_found && (r_best_val == r_aim);
    assign res_off = r_found ? res_d[OFF_W-1:0] : '0;

    always_comb begin
        if (r_term) begin
            res_code = {1'b0, r_seq_length, 1'b1};
        end else if (r_found) begin
            res_code = {res_d[CODE_W-2:0], res_eq};
        end else begin
            res_code = CODE_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_found  <= r_found && !r_term;
            r_out_offset <= r_term ? '0 : res_off;
            r_out_equal  <= res_eq && !r_term;
            r_out_code   <= res_code;
            r_out_term   <= r_term;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_out_found;
    assign o_pred_offset = r_out_offset;
    assign o_equal_flag  = r_out_equal;
    assign o_code        = $signed(r_out_code);
    assign o_terminal    = r_out_term;

`ifndef SYNTHESIS
    a_term_skips_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_query && q_term) |=> (r_state == S_DONE) && r_term)
        else $error("terminal query did not go straight to the result");

    a_write_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !is_query) |=> (r_state == S_IDLE))
        else $error("write request left the idle state");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cmp_pos < r_b) && (r_cmp_pos >= r_start_pos))
        else $error("scan position outside the query range");

    a_best_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_found) |-> (r_best_pos < r_b) && (r_best_val <= r_aim))
        else $error("predecessor outside the range or above the aim value");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result posted outside the result state");
`endif

endmodule
